>>> src/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/wsd_pkg.sv
package wsd_pkg;

    typedef enum logic [1:0] {
        WAVE_PCM8    = 2'd0,
        WAVE_PCM16   = 2'd1,
        WAVE_ADPCM   = 2'd2,
        WAVE_UNKNOWN = 2'd3
    } t_wave_kind;

    typedef logic [2:0] t_phase;

    localparam t_phase PH_PRED_LO = 3'd0;
    localparam t_phase PH_PRED_HI = 3'd1;
    localparam t_phase PH_IDX_LO  = 3'd2;
    localparam t_phase PH_IDX_HI  = 3'd3;
    localparam t_phase PH_DATA    = 3'd4;

    localparam logic [6:0] IDX_MAX = 7'd88;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;

    // IMA step size for a given step index.
    function automatic logic [14:0] step_lut(input logic [6:0] idx);
        logic [14:0] s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794; 7'd88: s = 15'd32767;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    // Step index adjustment for the magnitude bits of a nibble.
    function automatic logic signed [4:0] idx_adj(input logic [2:0] mag);
        logic signed [4:0] a;
        case (mag)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

>>> src/wave_sample_decoder.sv
// Wave sample decoder: raw wave bytes in, signed 16-bit samples out. The wave type register
// selects 8-bit PCM (one sample per byte), 16-bit little-endian PCM (one sample per byte
// pair) or 4-bit IMA ADPCM (a four-byte header, then two samples per byte, low nibble
// first); the unknown type produces nothing. i_first restarts the header and byte pairing.
// A byte is registered on acceptance and handled once the output register is free; PCM
// and header bytes are handled whole, an ADPCM data byte one nibble at a time, as the
// single nibble step unit and the output register handle one nibble per cycle while the
// output does not stall. The first sample of a byte passes through the byte register and
// then the output register; the second sample of an ADPCM data byte follows once the
// output register is free again. The output register lets the next byte be taken while
// a sample waits. The wave type may only be written while the block is idle.
module wave_sample_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_first,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_wave_kind
);
    import wsd_pkg::*;

    `include "assert_macros.svh"

    t_wave_kind         r_wave_kind;
    logic               r_valid;
    logic [7:0]         r_byte;
    logic               r_first;
    logic               r_nib;
    t_phase             r_phase;
    logic [7:0]         r_held;
    logic [15:0]        r_pred;
    logic [6:0]         r_step_pos;
    logic               r_out_valid;
    logic signed [15:0] r_out_sample;
    logic               r_out_last;

    logic               n_nib;
    t_phase             n_phase;
    logic [7:0]         n_held;
    logic [15:0]        n_pred;
    logic [6:0]         n_step_pos;

    logic               out_free;
    logic               fire;
    logic               done;
    logic               emit;
    logic signed [15:0] emit_sample;
    logic               emit_last;
    t_phase             eff_phase;

    // Nibble step datapath.
    logic [3:0]         nib;
    logic [6:0]         si;
    logic [14:0]        step;
    logic signed [8:0]  ni;
    logic [6:0]         ni_clamp;
    logic [16:0]        diff;
    logic signed [17:0] pred_sum;
    logic signed [15:0] pred_new;

    // PCM8 scaling.
    logic signed [17:0] pcm8_prod;
    logic signed [15:0] pcm8_sample;
    logic [15:0]        idx_word;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign fire      = r_valid && out_free;
    assign eff_phase = (r_first && !r_nib) ? PH_PRED_LO : r_phase;

    always_comb begin
        nib      = r_nib ? r_byte[7:4] : r_byte[3:0];
        si       = (r_step_pos > IDX_MAX) ? IDX_MAX : r_step_pos;
        step     = step_lut(si);
        ni       = $signed({2'b00, si}) + 9'(idx_adj(nib[2:0]));
        if (ni < 0) begin
            ni_clamp = 7'd0;
        end else if (ni > $signed({2'b00, IDX_MAX})) begin
            ni_clamp = IDX_MAX;
        end else begin
            ni_clamp = ni[6:0];
        end
        diff = 17'(step >> 3);
        if (nib[0]) begin
            diff = diff + 17'(step >> 2);
        end
        if (nib[1]) begin
            diff = diff + 17'(step >> 1);
        end
        if (nib[2]) begin
            diff = diff + 17'(step);
        end
        if (nib[3]) begin
            pred_sum = 18'($signed(r_pred)) - $signed({1'b0, diff});
        end else begin
            pred_sum = 18'($signed(r_pred)) + $signed({1'b0, diff});
        end
        if (pred_sum > 18'(SAMPLE_MAX)) begin
            pred_new = SAMPLE_MAX;
        end else if (pred_sum < 18'(SAMPLE_MIN)) begin
            pred_new = SAMPLE_MIN;
        end else begin
            pred_new = pred_sum[15:0];
        end
    end

    // Only -128 falls outside the 16-bit range after scaling by 258.
    always_comb begin
        pcm8_prod = 18'($signed(r_byte)) * 18'sd258;
        if (pcm8_prod < 18'(SAMPLE_MIN)) begin
            pcm8_sample = SAMPLE_MIN;
        end else begin
            pcm8_sample = pcm8_prod[15:0];
        end
    end

    assign idx_word = {r_byte, r_held};

    always_comb begin
        n_nib       = r_nib;
        n_phase     = r_phase;
        n_held      = r_held;
        n_pred      = r_pred;
        n_step_pos  = r_step_pos;
        done        = 1'b1;
        emit        = 1'b0;
        emit_sample = $signed({r_byte, r_held});
        emit_last   = 1'b1;
        unique case (r_wave_kind)
            WAVE_PCM8: begin
                n_phase     = eff_phase;
                emit        = 1'b1;
                emit_sample = pcm8_sample;
            end
            WAVE_PCM16: begin
                if (eff_phase == PH_PRED_LO) begin
                    n_held  = r_byte;
                    n_phase = PH_PRED_HI;
                end else begin
                    n_phase = PH_PRED_LO;
                    emit    = 1'b1;
                end
            end
            WAVE_ADPCM: begin
                case (eff_phase)
                    PH_PRED_LO, PH_IDX_LO: begin
                        n_held  = r_byte;
                        n_phase = eff_phase + 3'd1;
                    end
                    PH_PRED_HI: begin
                        n_pred  = {r_byte, r_held};
                        n_phase = PH_IDX_LO;
                    end
                    PH_IDX_HI: begin
                        n_step_pos = (idx_word > 16'(IDX_MAX)) ? IDX_MAX : idx_word[6:0];
                        n_phase    = PH_DATA;
                    end
                    default: begin
                        n_phase     = PH_DATA;
                        n_pred      = pred_new;
                        n_step_pos  = ni_clamp;
                        emit        = 1'b1;
                        emit_sample = pred_new;
                        emit_last   = r_nib;
                        done        = r_nib;
                        n_nib       = !r_nib;
                    end
                endcase
            end
            default: begin
                n_phase = eff_phase;
            end
        endcase
    end

    assign o_in_stall  = r_valid && !(fire && done);
    assign o_cfg_ready = !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_kind <= WAVE_PCM8;
            r_valid     <= 1'b0;
            r_nib       <= 1'b0;
            r_phase     <= PH_PRED_LO;
            r_held      <= 8'd0;
            r_pred      <= 16'd0;
            r_step_pos  <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_wave_kind <= t_wave_kind'(i_cfg_wave_kind);
            end
            if (i_in_valid && !o_in_stall) begin
                r_valid <= 1'b1;
            end else if (fire && done) begin
                r_valid <= 1'b0;
            end
            if (fire) begin
                r_nib      <= n_nib;
                r_phase    <= n_phase;
                r_held     <= n_held;
                r_pred     <= n_pred;
                r_step_pos <= n_step_pos;
            end
            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_byte  <= i_data_byte;
            r_first <= i_first;
        end
        if (fire && emit) begin
            r_out_sample <= emit_sample;
            r_out_last   <= emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out_sample;
    assign o_last      = r_out_last;

    `ASSERT_ALWAYS(a_step_pos_range, i_clk, i_rst_n, r_step_pos <= IDX_MAX)
    `ASSERT_IMPLIES(a_high_nib_has_item, i_clk, i_rst_n, r_nib, r_valid)
    `ASSERT_NEXT(a_low_nib_not_last, i_clk, i_rst_n,
        fire && emit && !emit_last, o_out_valid && !o_last && r_nib)

endmodule
